@@ src/tdpm_pkg.sv @@
`default_nettype none
package tdpm_pkg;

    localparam int MAX_JOINTS = 6;
    localparam int ANGLE_W    = 32;
    localparam int VALUE_W    = 48;
    localparam int DIFF_W     = 50;

    localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;
    localparam logic [VALUE_W-1:0] POS_LIMIT    = 48'h7FFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_MAG      = 48'h8000_0000_0000;

    localparam logic RECORD_ROW  = 1'b0;
    localparam logic RECORD_PEAK = 1'b1;

    typedef struct packed {
        logic [31:0]        sample_time;
        logic signed [31:0] angle_0;
        logic signed [31:0] angle_1;
        logic signed [31:0] angle_2;
        logic signed [31:0] angle_3;
        logic signed [31:0] angle_4;
        logic signed [31:0] angle_5;
        logic               end_of_path;
    } t_sample;

    typedef struct packed {
        logic               record_kind;
        logic [2:0]         joint_index;
        logic signed [47:0] value_0;
        logic signed [47:0] value_1;
        logic signed [47:0] value_2;
        logic signed [47:0] value_3;
        logic signed [47:0] value_4;
        logic signed [47:0] value_5;
        logic               zero_interval;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] diff;
        logic [31:0]              dt;
    } t_div_req;

    function automatic logic [VALUE_W-1:0] f_mag(input logic signed [VALUE_W-1:0] x);
        logic [VALUE_W-1:0] a;
        a = x[VALUE_W-1] ? (~x + 48'd1) : x;
        return (a > POS_LIMIT) ? POS_LIMIT : a;
    endfunction

endpackage
`default_nettype wire

@@ src/trajectory_derivative_peak_monitor.sv @@
`default_nettype none
// Per-joint velocity, acceleration and jerk monitor for timestamped joint samples.
// Input channel i_smp_valid / o_smp_ready carries one sample (time in us, six
// Q15.16 angles, end_of_path). Output channel o_res_valid / i_res_ready carries
// results: one jerk row per ordinary sample, JOINTS peak reports for the sample
// flagged end_of_path, after which all history and peaks return to zero.
// Samples are handled one at a time. With a nonzero interval, on each sample but
// the first of a path, each joint runs three divisions on the shared
// multiply/shift-subtract divider: one multiply by 1e6, one range check and 48
// quotient bits. The first sample of a path or a zero interval runs no division
// and gives zero rates. Peak reports follow one a cycle while i_res_ready is high.
// The result sits in an output register; a stalled receiver holds the block in its
// emit step, while the next sample can be taken once that register is loaded.
// Reset (synchronous, active low) clears the history, peaks and both channels.
module trajectory_derivative_peak_monitor #(
    parameter int JOINTS = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_smp_valid,
    output logic                   o_smp_ready,
    input  wire tdpm_pkg::t_sample i_smp,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output tdpm_pkg::t_result      o_res
);

    localparam int NJ = tdpm_pkg::MAX_JOINTS;
    localparam int VW = tdpm_pkg::VALUE_W;
    localparam int DW = tdpm_pkg::DIFF_W;
    localparam logic [2:0] LAST_J = 3'(JOINTS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_VEL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_JRK  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_ROW  = 3'd6;
    localparam logic [2:0] S_PEAK = 3'd7;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [2:0]            r_j;
    logic                  r_first;
    logic [31:0]           r_prev_time;
    logic [31:0]           r_dt;
    logic                  r_calc;
    logic                  r_zflag;
    logic                  r_last;
    logic signed [31:0]    r_ang  [NJ];
    logic signed [31:0]    r_pa   [NJ];
    logic signed [VW-1:0]  r_pv   [NJ];
    logic signed [VW-1:0]  r_pacc [NJ];
    logic [VW-1:0]         r_pkv  [NJ];
    logic [VW-1:0]         r_pka  [NJ];
    logic [VW-1:0]         r_pkj  [NJ];
    logic signed [VW-1:0]  r_jerk [NJ];
    logic signed [VW-1:0]  r_v;
    logic signed [VW-1:0]  r_a;
    logic signed [VW-1:0]  r_jk;
    logic                  r_out_valid;
    tdpm_pkg::t_result     r_out;

    tdpm_pkg::t_div_req    div_req;
    logic                  div_done;
    logic signed [VW-1:0]  div_quot;
    logic                  accept;
    logic                  slot_free;
    logic                  out_load;
    logic [31:0]           dt_in;
    logic [VW-1:0]         mag_v;
    logic [VW-1:0]         mag_a;
    logic [VW-1:0]         mag_j;

    assign o_smp_ready = (r_state == S_IDLE);
    assign accept      = i_smp_valid && o_smp_ready;
    assign slot_free   = !r_out_valid || i_res_ready;
    assign out_load    = slot_free && ((r_state == S_ROW) || (r_state == S_PEAK));
    assign dt_in       = i_smp.sample_time - r_prev_time;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign mag_v       = tdpm_pkg::f_mag(r_v);
    assign mag_a       = tdpm_pkg::f_mag(r_a);
    assign mag_j       = tdpm_pkg::f_mag(r_jk);

    always_comb begin
        div_req.dt    = r_dt;
        div_req.start = 1'b0;
        div_req.diff  = DW'(r_ang[r_j]) - DW'(r_pa[r_j]);
        unique case (r_state)
            S_PREP: begin
                div_req.start = r_calc;
            end
            S_VEL: begin
                div_req.start = div_done;
                div_req.diff  = DW'(div_quot) - DW'(r_pv[r_j]);
            end
            S_ACC: begin
                div_req.start = div_done;
                div_req.diff  = DW'(div_quot) - DW'(r_pacc[r_j]);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    tdpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_PREP;
            S_PREP: n_state = r_calc ? S_VEL : S_UPD;
            S_VEL:  if (div_done) n_state = S_ACC;
            S_ACC:  if (div_done) n_state = S_JRK;
            S_JRK:  if (div_done) n_state = S_UPD;
            S_UPD: begin
                if (r_j != LAST_J) begin
                    n_state = S_PREP;
                end else begin
                    n_state = r_last ? S_PEAK : S_ROW;
                end
            end
            S_ROW:  if (slot_free) n_state = S_IDLE;
            S_PEAK: if (slot_free && (r_j == LAST_J)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= 3'd0;
            r_first     <= 1'b0;
            r_prev_time <= 32'd0;
            r_out_valid <= 1'b0;
            r_calc      <= 1'b0;
            r_zflag     <= 1'b0;
            r_last      <= 1'b0;
            for (int i = 0; i < NJ; i++) begin
                r_pa[i]   <= '0;
                r_pv[i]   <= '0;
                r_pacc[i] <= '0;
                r_pkv[i]  <= '0;
                r_pka[i]  <= '0;
                r_pkj[i]  <= '0;
                r_jerk[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ang[0]    <= i_smp.angle_0;
                        r_ang[1]    <= i_smp.angle_1;
                        r_ang[2]    <= i_smp.angle_2;
                        r_ang[3]    <= i_smp.angle_3;
                        r_ang[4]    <= i_smp.angle_4;
                        r_ang[5]    <= i_smp.angle_5;
                        r_last      <= i_smp.end_of_path;
                        r_dt        <= dt_in;
                        r_calc      <= r_first && (dt_in != 32'd0);
                        r_zflag     <= r_first && (dt_in == 32'd0);
                        r_prev_time <= i_smp.sample_time;
                        r_first     <= 1'b1;
                        r_j         <= 3'd0;
                    end
                end
                S_PREP: begin
                    if (!r_calc) begin
                        r_v  <= '0;
                        r_a  <= '0;
                        r_jk <= '0;
                    end
                end
                S_VEL: if (div_done) r_v <= div_quot;
                S_ACC: if (div_done) r_a <= div_quot;
                S_JRK: if (div_done) r_jk <= div_quot;
                S_UPD: begin
                    r_pa[r_j]   <= r_ang[r_j];
                    r_pv[r_j]   <= r_v;
                    r_pacc[r_j] <= r_a;
                    r_jerk[r_j] <= r_jk;
                    if (mag_v > r_pkv[r_j]) r_pkv[r_j] <= mag_v;
                    if (mag_a > r_pka[r_j]) r_pka[r_j] <= mag_a;
                    if (mag_j > r_pkj[r_j]) r_pkj[r_j] <= mag_j;
                    r_j <= (r_j == LAST_J) ? 3'd0 : r_j + 3'd1;
                end
                S_ROW: begin
                    if (slot_free) begin
                        r_out.record_kind   <= tdpm_pkg::RECORD_ROW;
                        r_out.joint_index   <= 3'd0;
                        r_out.value_0       <= r_jerk[0];
                        r_out.value_1       <= r_jerk[1];
                        r_out.value_2       <= r_jerk[2];
                        r_out.value_3       <= r_jerk[3];
                        r_out.value_4       <= r_jerk[4];
                        r_out.value_5       <= r_jerk[5];
                        r_out.zero_interval <= r_zflag;
                        r_out.last_result   <= 1'b1;
                    end
                end
                S_PEAK: begin
                    if (slot_free) begin
                        r_out.record_kind   <= tdpm_pkg::RECORD_PEAK;
                        r_out.joint_index   <= r_j;
                        r_out.value_0       <= r_pkv[r_j];
                        r_out.value_1       <= r_pka[r_j];
                        r_out.value_2       <= r_pkj[r_j];
                        r_out.value_3       <= '0;
                        r_out.value_4       <= '0;
                        r_out.value_5       <= '0;
                        r_out.zero_interval <= r_zflag;
                        r_out.last_result   <= (r_j == LAST_J);
                        r_j                 <= (r_j == LAST_J) ? 3'd0 : r_j + 3'd1;
                        if (r_j == LAST_J) begin
                            r_first     <= 1'b0;
                            r_prev_time <= 32'd0;
                            for (int i = 0; i < NJ; i++) begin
                                r_pa[i]   <= '0;
                                r_pv[i]   <= '0;
                                r_pacc[i] <= '0;
                                r_pkv[i]  <= '0;
                                r_pka[i]  <= '0;
                                r_pkj[i]  <= '0;
                                r_jerk[i] <= '0;
                            end
                        end
                    end
                end
                default: begin
                    r_j <= r_j;
                end
            endcase
        end
    end

    a_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_VEL || r_state == S_ACC || r_state == S_JRK))
        else $error("divider finished outside a derivative step");

    a_path_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEAK && slot_free && r_j == LAST_J)
        |=> (!r_first && r_state == S_IDLE && r_out_valid && r_out.last_result))
        else $error("end of path did not clear history");

    a_zero_no_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_zflag && r_state != S_IDLE) |-> !r_calc)
        else $error("zero interval sample started a division");

endmodule
`default_nettype wire

@@ src/tdpm_div.sv @@
`default_nettype none
module tdpm_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tdpm_pkg::t_div_req         i_req,
    output logic                            o_done,
    output logic signed [tdpm_pkg::VALUE_W-1:0] o_quot
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic [1:0]  r_state;
    logic        r_chk;
    logic        r_neg;
    logic        r_sat;
    logic [48:0] r_mag;
    logic [68:0] r_num;
    logic [31:0] r_dt;
    logic [31:0] r_rem;
    logic [47:0] r_low;
    logic [47:0] r_q;
    logic [5:0]  r_cnt;

    logic [32:0] rem_sh;
    logic        ge;
    logic [47:0] lim;
    logic [47:0] val;

    assign rem_sh = {r_rem, r_low[47]};
    assign ge     = rem_sh >= {1'b0, r_dt};
    assign lim    = r_neg ? tdpm_pkg::NEG_MAG : tdpm_pkg::POS_LIMIT;
    assign val    = (r_sat || (r_q > lim)) ? lim : r_q;
    assign o_quot = r_neg ? (~val + 48'd1) : val;
    assign o_done = (r_state == D_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_chk   <= 1'b0;
            r_cnt   <= 6'd0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.diff[tdpm_pkg::DIFF_W-1];
                        r_mag   <= i_req.diff[tdpm_pkg::DIFF_W-1]
                                   ? 49'(-i_req.diff) : 49'(i_req.diff);
                        r_dt    <= i_req.dt;
                        r_state <= D_MUL;
                        r_chk   <= 1'b0;
                    end
                end
                D_MUL: begin
                    if (!r_chk) begin
                        r_num <= 69'(r_mag) * 69'(tdpm_pkg::USEC_PER_SEC);
                        r_chk <= 1'b1;
                    end else begin
                        r_sat   <= 32'(r_num[68:48]) >= r_dt;
                        r_rem   <= 32'(r_num[68:48]);
                        r_low   <= r_num[47:0];
                        r_q     <= 48'd0;
                        r_cnt   <= 6'd0;
                        r_state <= D_DIV;
                    end
                end
                D_DIV: begin
                    r_rem <= ge ? 32'(rem_sh - {1'b0, r_dt}) : rem_sh[31:0];
                    r_low <= {r_low[46:0], 1'b0};
                    r_q   <= {r_q[46:0], ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) begin
                        r_state <= D_DONE;
                    end
                end
                D_DONE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.diff[tdpm_pkg::DIFF_W-1];
                        r_mag   <= i_req.diff[tdpm_pkg::DIFF_W-1]
                                   ? 49'(-i_req.diff) : 49'(i_req.diff);
                        r_dt    <= i_req.dt;
                        r_state <= D_MUL;
                        r_chk   <= 1'b0;
                    end else begin
                        r_state <= D_IDLE;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ tb/trajectory_derivative_peak_monitor_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module trajectory_derivative_peak_monitor_tb;

    localparam int  NJ        = 6;
    localparam int  STALL_CAP = 40000;
    localparam logic [47:0] VMAX = 48'h7FFF_FFFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_smp_valid;
    logic              o_smp_ready;
    tdpm_pkg::t_sample i_smp;
    logic              o_res_valid;
    logic              i_res_ready;
    tdpm_pkg::t_result o_res;

    trajectory_derivative_peak_monitor #(.JOINTS(NJ)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_smp_valid(i_smp_valid), .o_smp_ready(o_smp_ready), .i_smp(i_smp),
        .o_res_valid(o_res_valid), .i_res_ready(i_res_ready), .o_res(o_res)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    tdpm_pkg::t_sample pending_samples[$];
    tdpm_pkg::t_result expected_results[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  quiet_phase = 0;
    bit  hold_sender = 0;
    int  send_gap = 0;
    int  recv_gap = 0;

    bit                 seen;
    logic [31:0]        last_time;
    logic signed [63:0] last_ang [NJ];
    logic signed [63:0] last_vel [NJ];
    logic signed [63:0] last_acc [NJ];
    logic signed [63:0] pk_vel [NJ];
    logic signed [63:0] pk_acc [NJ];
    logic signed [63:0] pk_jrk [NJ];

    logic o_smp_ready_q;
    logic smp_taken;
    assign smp_taken = i_smp_valid && o_smp_ready;

    function automatic void clear_history();
        seen = 0;
        last_time = '0;
        for (int j = 0; j < NJ; j++) begin
            last_ang[j] = 0; last_vel[j] = 0; last_acc[j] = 0;
            pk_vel[j] = 0; pk_acc[j] = 0; pk_jrk[j] = 0;
        end
    endfunction

    function automatic logic signed [63:0] scaled_rate(logic signed [63:0] diff,
                                                       logic [31:0] dt);
        logic         neg;
        logic [63:0]  m;
        logic [127:0] prod;
        logic [127:0] q;
        logic [63:0]  lim;
        neg  = diff < 0;
        m    = neg ? -diff : diff;
        lim  = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
        prod = 128'(m) * 128'd1000000;
        q    = prod / 128'(dt);
        if (q > 128'(lim)) q = 128'(lim);
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] magnitude(logic signed [63:0] x);
        logic signed [63:0] a;
        a = x < 0 ? -x : x;
        return a > $signed({16'd0, VMAX}) ? $signed({16'd0, VMAX}) : a;
    endfunction

    function automatic void predict_sample(tdpm_pkg::t_sample s);
        logic [31:0]        dt;
        logic               zf;
        logic signed [31:0] ang [NJ];
        logic signed [63:0] jrk [NJ];
        logic signed [63:0] v, a, jk;
        tdpm_pkg::t_result  r;
        dt = s.sample_time - last_time;
        zf = seen && dt == 0;
        ang[0] = s.angle_0; ang[1] = s.angle_1; ang[2] = s.angle_2;
        ang[3] = s.angle_3; ang[4] = s.angle_4; ang[5] = s.angle_5;
        for (int j = 0; j < NJ; j++) begin
            v = 0; a = 0; jk = 0;
            if (seen && dt != 0) begin
                v  = scaled_rate(64'(ang[j]) - last_ang[j], dt);
                a  = scaled_rate(v - last_vel[j], dt);
                jk = scaled_rate(a - last_acc[j], dt);
            end
            last_ang[j] = 64'(ang[j]);
            last_vel[j] = v;
            last_acc[j] = a;
            jrk[j] = jk;
            if (magnitude(v) > pk_vel[j]) pk_vel[j] = magnitude(v);
            if (magnitude(a) > pk_acc[j]) pk_acc[j] = magnitude(a);
            if (magnitude(jk) > pk_jrk[j]) pk_jrk[j] = magnitude(jk);
        end
        last_time = s.sample_time;
        seen = 1;
        if (!s.end_of_path) begin
            r = '0;
            r.record_kind = tdpm_pkg::RECORD_ROW;
            r.value_0 = jrk[0][47:0]; r.value_1 = jrk[1][47:0];
            r.value_2 = jrk[2][47:0]; r.value_3 = jrk[3][47:0];
            r.value_4 = jrk[4][47:0]; r.value_5 = jrk[5][47:0];
            r.zero_interval = zf;
            r.last_result = 1'b1;
            expected_results = {expected_results, r};
        end else begin
            for (int k = 0; k < NJ; k++) begin
                r = '0;
                r.record_kind = tdpm_pkg::RECORD_PEAK;
                r.joint_index = 3'(k);
                r.value_0 = pk_vel[k][47:0];
                r.value_1 = pk_acc[k][47:0];
                r.value_2 = pk_jrk[k][47:0];
                r.zero_interval = zf;
                r.last_result = (k == NJ - 1);
                expected_results = {expected_results, r};
            end
            clear_history();
        end
    endfunction

    function automatic tdpm_pkg::t_sample make_sample(logic [31:0] t,
                                                      logic signed [31:0] a0,
                                                      logic signed [31:0] step,
                                                      logic eop);
        tdpm_pkg::t_sample s;
        s.sample_time = t;
        s.angle_0 = a0;
        s.angle_1 = a0 + step;
        s.angle_2 = a0 - step;
        s.angle_3 = -a0;
        s.angle_4 = a0 ^ step;
        s.angle_5 = step;
        s.end_of_path = eop;
        return s;
    endfunction

    function automatic logic signed [31:0] random_angle();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom);
            default: return $signed($urandom_range(0, 2000000)) - 32'sd1000000;
        endcase
    endfunction

    function automatic logic [31:0] random_interval();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return $urandom;
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    task automatic add_random_path(int len);
        logic [31:0]       t;
        tdpm_pkg::t_sample s;
        t = $urandom;
        for (int i = 0; i < len; i++) begin
            t = t + random_interval();
            s.sample_time = t;
            s.angle_0 = random_angle(); s.angle_1 = random_angle();
            s.angle_2 = random_angle(); s.angle_3 = random_angle();
            s.angle_4 = random_angle(); s.angle_5 = random_angle();
            s.end_of_path = (i == len - 1);
            pending_samples = {pending_samples, s};
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_smp_valid <= 1'b0;
            i_res_ready <= 1'b0;
            i_smp       <= '0;
        end else begin
            if (!i_smp_valid || o_smp_ready_q) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_smp_valid <= 1'b0;
                end else if (!hold_sender && pending_samples.size() > 0) begin
                    i_smp <= pending_samples.pop_front();
                    i_smp_valid <= 1'b1;
                    if (!quiet_phase && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 13);
                end else begin
                    i_smp_valid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 13);
            end
        end
    end

    always @(posedge i_clk) begin
        tdpm_pkg::t_result want;
        o_smp_ready_q <= smp_taken;
        if (i_rst_n) begin
            if (smp_taken || (o_res_valid && i_res_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (smp_taken)
                predict_sample(i_smp);
            if (o_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_res);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_res !== want) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, o_res);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles > STALL_CAP) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || i_smp_valid || o_smp_ready_q
               || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        clear_history();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_samples = {pending_samples, make_sample(32'd0, 32'sd0, 32'sd0, 1'b1)};
        pending_samples = {pending_samples,
                           make_sample(32'd1000, 32'sh7FFF_FFFF, 32'sd1, 1'b0)};
        pending_samples = {pending_samples,
                           make_sample(32'd1001, 32'sh8000_0000, -32'sd1, 1'b0)};
        pending_samples = {pending_samples,
                           make_sample(32'd1001, 32'sd65536, 32'sd5, 1'b0)};
        pending_samples = {pending_samples,
                           make_sample(32'd1002, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0)};
        pending_samples = {pending_samples, make_sample(32'd0, 32'sd100, 32'sd3, 1'b0)};
        pending_samples = {pending_samples,
                           make_sample(32'hFFFF_FFFF, -32'sd100, 32'sd7, 1'b0)};
        pending_samples = {pending_samples,
                           make_sample(32'hFFFF_FFFF, 32'sd0, 32'sd0, 1'b1)};
        pending_samples = {pending_samples,
                           make_sample(32'h1234_5678, 32'sd65536, 32'sd65536, 1'b0)};
        pending_samples = {pending_samples,
                           make_sample(32'h1234_6A78, 32'sd131072, 32'sd1000, 1'b0)};
        pending_samples = {pending_samples,
                           make_sample(32'h1234_7E78, 32'sd65536, -32'sd1000, 1'b1)};
        wait_drained();

        hold_sender = 1;
        for (int n = 0; n < 430; ) begin
            int len;
            len = $urandom_range(1, 12);
            add_random_path(len);
            n += len;
        end
        hold_sender = 0;
        while (pending_samples.size() > 50)
            @(posedge i_clk);
        quiet_phase = 1;
        wait_drained();
        repeat (2000) begin
            @(posedge i_clk);
            if (o_res_valid) break;
        end
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

@@ trajectory_derivative_peak_monitor.f @@
src/tdpm_pkg.sv
src/tdpm_div.sv
src/trajectory_derivative_peak_monitor.sv
tb/trajectory_derivative_peak_monitor_tb.sv
